// File: src/ucfr_pkg.sv
// Package for the UART command frame receiver: shared types, constants and
// the byte-wide CRC-16/X.25 update function. No dependencies.
package ucfr_pkg;

  localparam logic [7:0]  FRAME_START_RST  = 8'h5a;
  localparam logic [15:0] UPD_TIMEOUT_RST  = 16'd60000;
  localparam logic [15:0] CRC_INIT         = 16'hffff;
  localparam logic [15:0] CRC_POLY_REFL    = 16'h8408;
  localparam logic [7:0]  HS_OPEN0         = 8'h20;
  localparam logic [7:0]  HS_OPEN1         = 8'h06;
  localparam logic [7:0]  HS_FILL_A        = 8'h55;
  localparam logic [7:0]  HS_FILL_B        = 8'haa;
  localparam logic [2:0]  CRC_SPAN         = 3'd6;
  localparam logic [2:0]  FRAME_LAST_POS   = 3'd7;
  localparam logic [2:0]  HS_LAST_POS      = 3'd7;

  localparam int unsigned CFG_AW = 3;

  typedef enum logic {
    ACT_BYTE = 1'b0,
    ACT_TICK = 1'b1
  } action_t;

  typedef enum logic {
    REG_FRAME_START = 1'b0,
    REG_UPD_TIMEOUT = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic       action;
    logic [7:0] rx_byte;
    logic       from_known_port;
  } item_t;

  // Status from the handshake unit to the frame gatherer and result stage
  typedef struct packed {
    logic update_mode;
    logic gather;
    logic forwarded;
  } hs_stat_t;

  typedef struct packed {
    logic        frame_ready;
    logic [63:0] frame_bytes;
    logic        crc_mismatch;
  } frame_res_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY_REFL) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// File: src/ucfr_if.sv
// Handshake channels for input items and result items.
// Does not depend on ucfr_pkg; its widths match the package's fields.
interface ucfr_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] rx_byte;
  logic       from_known_port;

  modport source (output valid, action, rx_byte, from_known_port, input ready);
  modport sink (input valid, action, rx_byte, from_known_port, output ready);
endinterface

interface ucfr_out_if;
  logic        valid;
  logic        ready;
  logic        frame_ready;
  logic [63:0] frame_bytes;
  logic        crc_mismatch;
  logic        update_mode;
  logic        forwarded_to_update;

  modport source (output valid, frame_ready, frame_bytes, crc_mismatch, update_mode,
                  forwarded_to_update, input ready);
  modport sink (input valid, frame_ready, frame_bytes, crc_mismatch, update_mode,
                forwarded_to_update, output ready);
endinterface

// File: src/uart_command_frame_receiver.sv
// An accepted item passes through the input register, then the result register, before
// its result item appears. Throughput: one item per cycle while the output is not stalled,
// set by the combinational byte CRC update and state update between the two registers.
// Reset (rst_n low, synchronous): channels empty, frame position zero, CRC all ones,
// handshake idle, update mode off, registers at start byte 0x5A and timeout 60000.
module uart_command_frame_receiver (
  input  logic                clk,
  input  logic                rst_n,
  ucfr_in_if.sink             in_ch,
  ucfr_out_if.source          out_ch,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ucfr_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic [7:0]             start_byte_r;
  logic [15:0]            timeout_r;
  logic                   s1_v_r;
  ucfr_pkg::item_t        s1_item_r;
  logic                   out_v_r;
  ucfr_pkg::frame_res_t   out_frame_r;
  logic                   out_upd_r;
  logic                   out_fwd_r;
  logic                   adv;
  logic                   proc_en;
  logic                   in_acc;
  ucfr_pkg::hs_stat_t     hs_stat;
  ucfr_pkg::frame_res_t   frame_res;
  logic                   cfg_wr;
  ucfr_pkg::reg_idx_t     cfg_idx;

  // configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = ucfr_pkg::reg_idx_t'(paddr[2]);

  always_comb begin
    case (cfg_idx)
      ucfr_pkg::REG_FRAME_START: prdata = {24'd0, start_byte_r};
      ucfr_pkg::REG_UPD_TIMEOUT: prdata = {16'd0, timeout_r};
      default:                   prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r <= ucfr_pkg::FRAME_START_RST;
      timeout_r    <= ucfr_pkg::UPD_TIMEOUT_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        ucfr_pkg::REG_FRAME_START: start_byte_r <= pwdata[7:0];
        ucfr_pkg::REG_UPD_TIMEOUT: timeout_r    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // pipeline control: advance whenever the result register is free or being taken
  assign adv         = !out_v_r || out_ch.ready;
  assign in_ch.ready = !s1_v_r || adv;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign proc_en     = s1_v_r && adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r.action          <= in_ch.action;
      s1_item_r.rx_byte         <= in_ch.rx_byte;
      s1_item_r.from_known_port <= in_ch.from_known_port;
    end
  end

  ucfr_handshake u_hs (
    .clk     (clk),
    .rst_n   (rst_n),
    .proc_en (proc_en),
    .item    (s1_item_r),
    .timeout (timeout_r),
    .stat    (hs_stat)
  );

  ucfr_frame u_frame (
    .clk        (clk),
    .rst_n      (rst_n),
    .proc_en    (proc_en),
    .gather     (hs_stat.gather),
    .rx_byte    (s1_item_r.rx_byte),
    .start_byte (start_byte_r),
    .res        (frame_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_en) begin
      out_frame_r <= frame_res;
      out_upd_r   <= hs_stat.update_mode;
      out_fwd_r   <= hs_stat.forwarded;
    end
  end

  assign out_ch.valid               = out_v_r;
  assign out_ch.frame_ready         = out_frame_r.frame_ready;
  assign out_ch.frame_bytes         = out_frame_r.frame_bytes;
  assign out_ch.crc_mismatch        = out_frame_r.crc_mismatch;
  assign out_ch.update_mode         = out_upd_r;
  assign out_ch.forwarded_to_update = out_fwd_r;

  a_pass_fail_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> !(out_frame_r.frame_ready && out_frame_r.crc_mismatch))
    else $error("frame reported as both passed and failed");

  a_fwd_in_update: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_fwd_r |-> out_upd_r)
    else $error("item forwarded while update mode is off");

  a_frame_not_in_update: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && (out_frame_r.frame_ready || out_frame_r.crc_mismatch) |-> !out_upd_r)
    else $error("frame completed while update mode is on");

  a_bytes_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_frame_r.frame_ready && !out_frame_r.crc_mismatch
      |-> out_frame_r.frame_bytes == 64'd0)
    else $error("frame bytes set without a completed frame");

  a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
    proc_en |=> out_v_r)
    else $error("processed item did not reach the result register");

endmodule

// File: src/ucfr_handshake.sv
// Update-mode handshake detector and millisecond timeout counter.
// Depends on ucfr_pkg (item_t, hs_stat_t, handshake constants).
module ucfr_handshake (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 proc_en,
  input  ucfr_pkg::item_t      item,
  input  logic [15:0]          timeout,
  output ucfr_pkg::hs_stat_t   stat
);

  logic [2:0]  hs_pos_r, hs_pos_nxt;
  logic        upd_r, upd_nxt;
  logic [15:0] elapsed_r, elapsed_nxt;
  logic        fill;
  logic [2:0]  restart;
  logic [15:0] el_inc;

  assign fill    = item.rx_byte inside {ucfr_pkg::HS_FILL_A, ucfr_pkg::HS_FILL_B};
  assign restart = (item.rx_byte == ucfr_pkg::HS_OPEN0) ? 3'd1 : 3'd0;
  assign el_inc  = (elapsed_r == 16'hffff) ? elapsed_r : elapsed_r + 16'd1;

  always_comb begin
    hs_pos_nxt  = hs_pos_r;
    upd_nxt     = upd_r;
    elapsed_nxt = elapsed_r;
    if (item.action == ucfr_pkg::ACT_TICK) begin
      if (upd_r) begin
        elapsed_nxt = el_inc;
        if (el_inc >= timeout) upd_nxt = 1'b0;
      end
    end else if (item.from_known_port) begin
      // drop update mode first if the timeout was lowered below elapsed
      if (upd_r && (elapsed_r >= timeout)) upd_nxt = 1'b0;
      case (hs_pos_r)
        3'd0: hs_pos_nxt = restart;
        3'd1: hs_pos_nxt = (item.rx_byte == ucfr_pkg::HS_OPEN1) ? 3'd2 : restart;
        3'd2, 3'd3: hs_pos_nxt = (item.rx_byte == 8'h00) ? hs_pos_r + 3'd1 : restart;
        3'd4, 3'd5, 3'd6: hs_pos_nxt = fill ? hs_pos_r + 3'd1 : restart;
        default: begin
          // hold on the last position: each further fill byte refreshes
          if (fill) begin
            upd_nxt     = 1'b1;
            elapsed_nxt = 16'd0;
          end else begin
            hs_pos_nxt = restart;
          end
        end
      endcase
    end
  end

  always_comb begin
    stat.update_mode = upd_nxt;
    stat.gather      = (item.action == ucfr_pkg::ACT_BYTE) && item.from_known_port && !upd_nxt;
    stat.forwarded   = (item.action == ucfr_pkg::ACT_BYTE) && item.from_known_port && upd_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hs_pos_r  <= 3'd0;
      upd_r     <= 1'b0;
      elapsed_r <= 16'd0;
    end else if (proc_en) begin
      hs_pos_r  <= hs_pos_nxt;
      upd_r     <= upd_nxt;
      elapsed_r <= elapsed_nxt;
    end
  end

endmodule

// File: src/ucfr_frame.sv
// Command frame gatherer with running CRC-16/X.25 check.
// Depends on ucfr_pkg (crc_feed, frame_res_t, frame constants).
module ucfr_frame (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  proc_en,
  input  logic                  gather,
  input  logic [7:0]            rx_byte,
  input  logic [7:0]            start_byte,
  output ucfr_pkg::frame_res_t  res
);

  logic [2:0]  pos_r, pos_nxt;
  logic [63:0] store_r, store_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [63:0] shifted;

  assign shifted = {store_r[55:0], rx_byte};

  always_comb begin
    pos_nxt   = pos_r;
    store_nxt = store_r;
    crc_nxt   = crc_r;
    res       = '0;
    if (gather) begin
      if (pos_r == 3'd0) begin
        // a byte other than the start byte is dropped here
        if (rx_byte == start_byte) begin
          store_nxt = {56'd0, rx_byte};
          crc_nxt   = ucfr_pkg::crc_feed(ucfr_pkg::CRC_INIT, rx_byte);
          pos_nxt   = 3'd1;
        end
      end else begin
        store_nxt = shifted;
        if (pos_r < ucfr_pkg::CRC_SPAN) crc_nxt = ucfr_pkg::crc_feed(crc_r, rx_byte);
        if (pos_r == ucfr_pkg::FRAME_LAST_POS) begin
          res.frame_ready  = (shifted[15:0] == ~crc_r);
          res.crc_mismatch = (shifted[15:0] != ~crc_r);
          res.frame_bytes  = shifted;
          pos_nxt          = 3'd0;
          crc_nxt          = ucfr_pkg::CRC_INIT;
        end else begin
          pos_nxt = pos_r + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= 3'd0;
      store_r <= 64'd0;
      crc_r   <= ucfr_pkg::CRC_INIT;
    end else if (proc_en) begin
      pos_r   <= pos_nxt;
      store_r <= store_nxt;
      crc_r   <= crc_nxt;
    end
  end

endmodule
